// ===== hdl/dsc_pkg.sv =====
// dsc_pkg: shared types and constants for the two-sensor direction counter
// no dependencies
package dsc_pkg;

  // tracker modes
  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_INWARD  = 2'd1,
    MODE_OUTWARD = 2'd2,
    MODE_HOLD    = 2'd3
  } mode_t;

  // event kind codes on the result channel
  localparam logic [1:0] KIND_IN     = 2'd0;
  localparam logic [1:0] KIND_OUT    = 2'd1;
  localparam logic [1:0] KIND_REPORT = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_WINDOW  = 2'd0;
  localparam logic [1:0] REG_HOLDOFF = 2'd1;
  localparam logic [1:0] REG_PERIOD  = 2'd2;

  localparam int TIMER_BITS  = 16;
  localparam int PERIOD_BITS = 20;
  localparam int TOTAL_BITS  = 16;

  localparam logic [TIMER_BITS-1:0]  WINDOW_RESET  = 16'd2000;
  localparam logic [TIMER_BITS-1:0]  HOLDOFF_RESET = 16'd4000;
  localparam logic [PERIOD_BITS-1:0] PERIOD_RESET  = 20'd60000;

  // result control from the step logic to the output register
  typedef struct packed {
    logic       emit;
    logic [1:0] kind;
  } res_ctl_t;

endpackage

// ===== hdl/dsc_step.sv =====
// dsc_step: combinational next-state and result logic for one tick
// depends on dsc_pkg
module dsc_step #(
  parameter int COUNT_BITS = 16
) (
  input  logic                             outside_active,
  input  logic                             inside_active,
  input  logic [dsc_pkg::TIMER_BITS-1:0]   window_ticks,
  input  logic [dsc_pkg::TIMER_BITS-1:0]   holdoff_ticks,
  input  logic [dsc_pkg::PERIOD_BITS-1:0]  period_ticks,
  input  dsc_pkg::mode_t                   mode,
  input  logic [dsc_pkg::TIMER_BITS-1:0]   phase_timer,
  input  logic [dsc_pkg::PERIOD_BITS-1:0]  period_elapsed,
  input  logic [COUNT_BITS-1:0]            in_count,
  input  logic [COUNT_BITS-1:0]            out_count,
  output dsc_pkg::mode_t                   mode_nxt,
  output logic [dsc_pkg::TIMER_BITS-1:0]   phase_timer_nxt,
  output logic [dsc_pkg::PERIOD_BITS-1:0]  period_elapsed_nxt,
  output logic [COUNT_BITS-1:0]            in_count_nxt,
  output logic [COUNT_BITS-1:0]            out_count_nxt,
  output dsc_pkg::res_ctl_t                res_ctl
);

  logic [dsc_pkg::PERIOD_BITS-1:0] elapsed_inc;
  logic [dsc_pkg::TIMER_BITS-1:0]  timer_inc;
  logic                            report;
  logic                            both;
  logic                            open_in;
  logic                            open_out;

  assign elapsed_inc = (&period_elapsed) ? period_elapsed
                                         : period_elapsed + 1'b1;
  assign timer_inc   = (&phase_timer) ? phase_timer : phase_timer + 1'b1;
  assign report      = (mode == dsc_pkg::MODE_IDLE) && (elapsed_inc >= period_ticks);
  assign both        = outside_active && inside_active;
  assign open_in     = outside_active && !inside_active;
  assign open_out    = inside_active && !outside_active;

  // next mode
  always_comb begin
    mode_nxt = mode;
    case (mode)
      dsc_pkg::MODE_IDLE: begin
        if (!report && open_in) begin
          mode_nxt = dsc_pkg::MODE_INWARD;
        end else if (!report && open_out) begin
          mode_nxt = dsc_pkg::MODE_OUTWARD;
        end
      end
      dsc_pkg::MODE_INWARD, dsc_pkg::MODE_OUTWARD: begin
        if (both) begin
          mode_nxt = dsc_pkg::MODE_HOLD;
        end else if (timer_inc >= window_ticks) begin
          mode_nxt = dsc_pkg::MODE_IDLE;
        end
      end
      dsc_pkg::MODE_HOLD: begin
        if (timer_inc >= holdoff_ticks) begin
          mode_nxt = dsc_pkg::MODE_IDLE;
        end
      end
      default: mode_nxt = dsc_pkg::MODE_IDLE;
    endcase
  end

  // timers, counts and result
  always_comb begin
    phase_timer_nxt    = phase_timer;
    period_elapsed_nxt = elapsed_inc;
    in_count_nxt       = in_count;
    out_count_nxt      = out_count;
    res_ctl.emit       = 1'b0;
    res_ctl.kind       = dsc_pkg::KIND_REPORT;
    case (mode)
      dsc_pkg::MODE_IDLE: begin
        if (report) begin
          res_ctl.emit       = 1'b1;
          in_count_nxt       = '0;
          out_count_nxt      = '0;
          period_elapsed_nxt = '0;
        end else if (open_in || open_out) begin
          phase_timer_nxt = '0;
        end
      end
      dsc_pkg::MODE_INWARD, dsc_pkg::MODE_OUTWARD: begin
        phase_timer_nxt = timer_inc;
        if (both) begin
          res_ctl.emit    = 1'b1;
          phase_timer_nxt = '0;
          if (mode == dsc_pkg::MODE_INWARD) begin
            res_ctl.kind = dsc_pkg::KIND_IN;
            if (!(&in_count)) begin
              in_count_nxt = in_count + 1'b1;
            end
          end else begin
            res_ctl.kind = dsc_pkg::KIND_OUT;
            if (!(&out_count)) begin
              out_count_nxt = out_count + 1'b1;
            end
          end
        end
      end
      dsc_pkg::MODE_HOLD: begin
        phase_timer_nxt = timer_inc;
      end
      default: begin
        phase_timer_nxt = '0;
      end
    endcase
  end

endmodule

// ===== hdl/dsc_out_reg.sv =====
// dsc_out_reg: result register between the step logic and the result channel
// depends on dsc_pkg
module dsc_out_reg #(
  parameter int COUNT_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            load,
  input  dsc_pkg::res_ctl_t               res_ctl,
  input  logic [COUNT_BITS-1:0]           in_count,
  input  logic [COUNT_BITS-1:0]           out_count,
  output logic                            take_ok,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      out_event_kind,
  output logic [dsc_pkg::TOTAL_BITS-1:0]  out_in_total,
  output logic [dsc_pkg::TOTAL_BITS-1:0]  out_out_total
);

  localparam int WIDE_BITS = (COUNT_BITS > dsc_pkg::TOTAL_BITS) ? COUNT_BITS
                                                                 : dsc_pkg::TOTAL_BITS;

  logic                            valid_r;
  logic [1:0]                      kind_r;
  logic [dsc_pkg::TOTAL_BITS-1:0]  in_total_r;
  logic [dsc_pkg::TOTAL_BITS-1:0]  out_total_r;
  logic [WIDE_BITS-1:0]            in_wide;
  logic [WIDE_BITS-1:0]            out_wide;

  assign in_wide  = WIDE_BITS'(in_count);
  assign out_wide = WIDE_BITS'(out_count);

  // free slot when empty or the held transaction leaves this cycle
  assign take_ok = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load && res_ctl.emit) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res_ctl.emit) begin
      kind_r      <= res_ctl.kind;
      in_total_r  <= in_wide[dsc_pkg::TOTAL_BITS-1:0];
      out_total_r <= out_wide[dsc_pkg::TOTAL_BITS-1:0];
    end
  end

  assign out_valid      = valid_r;
  assign out_event_kind = kind_r;
  assign out_in_total   = in_total_r;
  assign out_out_total  = out_total_r;

endmodule

// ===== hdl/two_sensor_direction_counter.sv =====
// two_sensor_direction_counter: top level, state and configuration registers
// a tick's result, if it has one, is registered and appears on the output in the cycle after its tick transaction
// throughput: one tick per cycle; input stalls only while a held result is not taken
// reset (rst_n low, synchronous): idle mode, timers and counts zero,
// window 2000, hold-off 4000, period 60000 ticks
// depends on dsc_pkg, dsc_step, dsc_out_reg
module two_sensor_direction_counter #(
  parameter int COUNT_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // tick channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_outside_active,
  input  logic                              in_inside_active,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        out_event_kind,
  output logic [dsc_pkg::TOTAL_BITS-1:0]    out_in_total,
  output logic [dsc_pkg::TOTAL_BITS-1:0]    out_out_total,
  // configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [1:0]                        cfg_index,
  input  logic [dsc_pkg::PERIOD_BITS-1:0]   cfg_data
);

  // configuration registers
  logic [dsc_pkg::TIMER_BITS-1:0]  window_r;
  logic [dsc_pkg::TIMER_BITS-1:0]  holdoff_r;
  logic [dsc_pkg::PERIOD_BITS-1:0] period_r;

  // tracker state
  dsc_pkg::mode_t                  mode_r;
  dsc_pkg::mode_t                  mode_nxt;
  logic [dsc_pkg::TIMER_BITS-1:0]  phase_timer_r;
  logic [dsc_pkg::TIMER_BITS-1:0]  phase_timer_nxt;
  logic [dsc_pkg::PERIOD_BITS-1:0] period_elapsed_r;
  logic [dsc_pkg::PERIOD_BITS-1:0] period_elapsed_nxt;
  logic [COUNT_BITS-1:0]           in_count_r;
  logic [COUNT_BITS-1:0]           in_count_nxt;
  logic [COUNT_BITS-1:0]           out_count_r;
  logic [COUNT_BITS-1:0]           out_count_nxt;

  dsc_pkg::res_ctl_t               res_ctl;
  logic                            take_ok;
  logic                            in_fire;

  // counts handed to the result register
  logic [COUNT_BITS-1:0]           in_shown;
  logic [COUNT_BITS-1:0]           out_shown;

  // config writes are always taken; index 3 is ignored
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r  <= dsc_pkg::WINDOW_RESET;
      holdoff_r <= dsc_pkg::HOLDOFF_RESET;
      period_r  <= dsc_pkg::PERIOD_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        dsc_pkg::REG_WINDOW:  window_r  <= cfg_data[dsc_pkg::TIMER_BITS-1:0];
        dsc_pkg::REG_HOLDOFF: holdoff_r <= cfg_data[dsc_pkg::TIMER_BITS-1:0];
        dsc_pkg::REG_PERIOD:  period_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // a tick is taken whenever the result register can absorb its result
  assign in_ready = take_ok;
  assign in_fire  = in_valid && take_ok;

  dsc_step #(
    .COUNT_BITS(COUNT_BITS)
  ) u_step (
    .outside_active     (in_outside_active),
    .inside_active      (in_inside_active),
    .window_ticks       (window_r),
    .holdoff_ticks      (holdoff_r),
    .period_ticks       (period_r),
    .mode               (mode_r),
    .phase_timer        (phase_timer_r),
    .period_elapsed     (period_elapsed_r),
    .in_count           (in_count_r),
    .out_count          (out_count_r),
    .mode_nxt           (mode_nxt),
    .phase_timer_nxt    (phase_timer_nxt),
    .period_elapsed_nxt (period_elapsed_nxt),
    .in_count_nxt       (in_count_nxt),
    .out_count_nxt      (out_count_nxt),
    .res_ctl            (res_ctl)
  );

  // state advances once per accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r           <= dsc_pkg::MODE_IDLE;
      phase_timer_r    <= '0;
      period_elapsed_r <= '0;
      in_count_r       <= '0;
      out_count_r      <= '0;
    end else if (in_fire) begin
      mode_r           <= mode_nxt;
      phase_timer_r    <= phase_timer_nxt;
      period_elapsed_r <= period_elapsed_nxt;
      in_count_r       <= in_count_nxt;
      out_count_r      <= out_count_nxt;
    end
  end

  // events carry counts after the increment, reports carry counts before
  // clearing, so pick the matching value for the result register
  assign in_shown  = (res_ctl.kind == dsc_pkg::KIND_REPORT) ? in_count_r  : in_count_nxt;
  assign out_shown = (res_ctl.kind == dsc_pkg::KIND_REPORT) ? out_count_r : out_count_nxt;

  dsc_out_reg #(
    .COUNT_BITS(COUNT_BITS)
  ) u_out (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (in_fire),
    .res_ctl        (res_ctl),
    .in_count       (in_shown),
    .out_count      (out_shown),
    .take_ok        (take_ok),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_event_kind (out_event_kind),
    .out_in_total   (out_in_total),
    .out_out_total  (out_out_total)
  );

endmodule
